>>> hdl/btm_pkg.sv
// Shared constants, types and helpers for the binary template matcher.
// No dependencies; imported by every module of the block.
package btm_pkg;

   // Default sizes handed to the top-level parameters
   localparam int MAX_SIZE_DEF  = 128;
   localparam int MAX_PAT_W_DEF = 32;
   localparam int MAX_PAT_H     = 3;

   // Output coordinate width, fixed by the result fields
   localparam int OUT_W = 7;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_TOP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_MID   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_BOT   = 3'd5;

   localparam logic [7:0]  RST_IMAGE_SIZE = 8'd96;
   localparam logic [1:0]  RST_PAT_HEIGHT = 2'd3;
   localparam logic [5:0]  RST_PAT_WIDTH  = 6'd20;
   localparam logic [31:0] RST_MASK_TOP   = 32'd262144;
   localparam logic [31:0] RST_MASK_MID   = 32'd923745;
   localparam logic [31:0] RST_MASK_BOT   = 32'd74898;

   // Result queue depth
   localparam int RSP_DEPTH = 3;

   // Pattern set-up as seen by the match stage (height and width already clamped)
   typedef struct packed {
      logic [1:0]  height;
      logic [5:0]  width;
      logic [31:0] mask_top;
      logic [31:0] mask_mid;
      logic [31:0] mask_bot;
   } btm_pat_type;

   typedef struct packed {
      logic [OUT_W-1:0] top_row;
      logic [OUT_W-1:0] top_col;
   } btm_rsp_type;

   // Mirror the low w bits so that mask column j lands on bit w-1-j
   function automatic logic [31:0] btm_mirror(input logic [31:0] m, input logic [5:0] w);
      logic [31:0] rev;
      logic [5:0]  sh;
      for (int j = 0; j < 32; j++) begin
         rev[31-j] = m[j];
      end
      sh = 6'd32 - w;
      return rev >> sh;
   endfunction

endpackage

>>> hdl/binary_template_match_2d_top.sv
// Top level of the binary template matcher: config registers, raster counters,
// pipeline control. Depends on btm_pkg, btm_line_store, btm_match, btm_rsp_fifo.
//
// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  req_pixel (1b)
// rsp       out  rsp_valid/rsp_ready  rsp_top_row (7b), rsp_top_col (7b)
// csr       in   csr_valid/csr_ready  csr_index (3b), csr_data (32b)
//
// One pixel item per clock. Stage 0 steps the row/column counters and issues the
// line-store read; stage 1 gets the two upper-row bits (bypassed when the same
// column was written the cycle before), shifts the window and runs the mask AND.
// A match lands in a 3-entry result queue at the end of stage 1, so rsp_valid
// rises at the edge after the one that takes the pixel.
// After reset the line store is swept to zero, one column per cycle: req_ready
// stays low until the sweep ends. csr writes are taken at any time.
// req_ready also drops while a csr write is offered, and while the queue entries
// plus the item in stage 1 reach RSP_DEPTH; rsp back-pressure stalls nothing else.
module binary_template_match_2d_top #(
   parameter int MAX_SIZE  = btm_pkg::MAX_SIZE_DEF,
   parameter int MAX_PAT_W = btm_pkg::MAX_PAT_W_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [btm_pkg::OUT_W-1:0]       rsp_top_row,
   output logic [btm_pkg::OUT_W-1:0]       rsp_top_col,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [btm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [btm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import btm_pkg::*;

   localparam int CW = $clog2(MAX_SIZE);        // counter / address width
   localparam int NW = CW + 1;                  // holds MAX_SIZE itself
   localparam int SW = (NW > 8) ? NW : 8;
   localparam int WW = (MAX_PAT_W < 32) ? MAX_PAT_W : 32;

   // ---- configuration registers ----
   logic [7:0]  size_ff, size_in;
   logic [1:0]  pat_h_ff, pat_h_in;
   logic [5:0]  pat_w_ff, pat_w_in;
   logic [31:0] mask_top_ff, mask_top_in;
   logic [31:0] mask_mid_ff, mask_mid_in;
   logic [31:0] mask_bot_ff, mask_bot_in;

   assign csr_ready = 1'b1;

   always_comb begin
      size_in     = size_ff;
      pat_h_in    = pat_h_ff;
      pat_w_in    = pat_w_ff;
      mask_top_in = mask_top_ff;
      mask_mid_in = mask_mid_ff;
      mask_bot_in = mask_bot_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_SIZE: size_in     = csr_data[7:0];
            REG_PAT_HEIGHT: pat_h_in    = csr_data[1:0];
            REG_PAT_WIDTH:  pat_w_in    = csr_data[5:0];
            REG_MASK_TOP:   mask_top_in = csr_data;
            REG_MASK_MID:   mask_mid_in = csr_data;
            REG_MASK_BOT:   mask_bot_in = csr_data;
            default: ;      // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= RST_IMAGE_SIZE;
         pat_h_ff    <= RST_PAT_HEIGHT;
         pat_w_ff    <= RST_PAT_WIDTH;
         mask_top_ff <= RST_MASK_TOP;
         mask_mid_ff <= RST_MASK_MID;
         mask_bot_ff <= RST_MASK_BOT;
      end else begin
         size_ff     <= size_in;
         pat_h_ff    <= pat_h_in;
         pat_w_ff    <= pat_w_in;
         mask_top_ff <= mask_top_in;
         mask_mid_ff <= mask_mid_in;
         mask_bot_ff <= mask_bot_in;
      end
   end

   // ---- clamped settings ----
   logic [SW-1:0] size_x;
   logic [NW-1:0] n_eff;
   btm_pat_type   pat;

   always_comb begin
      size_x = SW'(size_ff);
      if (size_x == '0) begin
         size_x = SW'(1);
      end else if (size_x > SW'(MAX_SIZE)) begin
         size_x = SW'(MAX_SIZE);
      end
      n_eff = size_x[NW-1:0];

      pat.height = pat_h_ff;
      if (pat_h_ff == 2'd0) begin
         pat.height = 2'd1;
      end else if (pat_h_ff > 2'(MAX_PAT_H)) begin
         pat.height = 2'(MAX_PAT_H);
      end
      pat.width = pat_w_ff;
      if (pat_w_ff == 6'd0) begin
         pat.width = 6'd1;
      end else if (pat_w_ff > 6'(WW)) begin
         pat.width = 6'(WW);
      end
      pat.mask_top = mask_top_ff;
      pat.mask_mid = mask_mid_ff;
      pat.mask_bot = mask_bot_ff;
   end

   // ---- stage 0: raster position of the incoming pixel ----
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [NW-1:0] r0, c0, r1, c1;
   logic          ls_busy;
   logic [1:0]    q_count;
   logic          s1_valid_ff;
   logic          req_take;

   // result credit: queue plus the item now in stage 1 must leave a free slot
   assign req_ready = !ls_busy && !csr_valid
                      && ((3'(q_count) + 3'(s1_valid_ff)) <= 3'(RSP_DEPTH - 1));
   assign req_take  = req_valid & req_ready;

   always_comb begin
      // settle counters left out of range by a size change
      c0 = NW'(col_ff);
      r0 = NW'(row_ff);
      if (c0 >= n_eff) begin
         c0 = '0;
         r0 = r0 + 1'b1;
      end
      if (r0 >= n_eff) begin
         r0 = '0;
      end
      // advance past this pixel
      c1 = c0 + 1'b1;
      r1 = r0;
      if (c1 >= n_eff) begin
         c1 = '0;
         r1 = r0 + 1'b1;
         if (r1 >= n_eff) begin
            r1 = '0;
         end
      end
      row_in = row_ff;
      col_in = col_ff;
      if (req_take) begin
         row_in = r1[CW-1:0];
         col_in = c1[CW-1:0];
      end
   end

   // ---- stage 1 registers ----
   logic          s1_valid_in;
   logic          s1_px_ff;
   logic [CW-1:0] s1_row_ff, s1_col_ff;

   assign s1_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_px_ff  <= req_pixel;
         s1_row_ff <= r0[CW-1:0];
         s1_col_ff <= c0[CW-1:0];
      end
   end

   // ---- line store: bit 0 = previous row, bit 1 = the row before ----
   logic [1:0] up_bits;

   btm_line_store #(
      .MAX_SIZE (MAX_SIZE)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (c0[CW-1:0]),
      .rd_data (up_bits),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({up_bits[0], s1_px_ff}),   // previous row ages by one
      .busy    (ls_busy)
   );

   // ---- window and mask test ----
   logic             hit;
   btm_rsp_type      hit_data;
   btm_rsp_type      rsp_data;

   btm_match #(
      .MAX_SIZE  (MAX_SIZE),
      .MAX_PAT_W (MAX_PAT_W)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_valid_ff),
      .pixel   (s1_px_ff),
      .up1     (up_bits[0]),
      .up2     (up_bits[1]),
      .row     (s1_row_ff),
      .col     (s1_col_ff),
      .pat     (pat),
      .hit     (hit),
      .top_row (hit_data.top_row),
      .top_col (hit_data.top_col)
   );

   // ---- result queue ----
   btm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .push_data (hit_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   assign rsp_top_row = rsp_data.top_row;
   assign rsp_top_col = rsp_data.top_col;

endmodule

>>> hdl/btm_line_store.sv
// Line store: two previous image rows, one 2-bit entry per column.
// Synchronous RAM with registered read, write-to-read bypass, clearing pass after reset.
// Depends on btm_pkg.
module btm_line_store #(
   parameter int MAX_SIZE = btm_pkg::MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(MAX_SIZE)-1:0] rd_addr,
   output logic [1:0]                  rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_SIZE)-1:0] wr_addr,
   input  logic [1:0]                  wr_data,
   output logic                        busy
);
   import btm_pkg::*;

   localparam int AW = $clog2(MAX_SIZE);

   logic [1:0]    mem [MAX_SIZE];
   logic [1:0]    rd_q_ff;
   logic          byp_hit_ff, byp_hit_in;
   logic [1:0]    byp_data_ff;
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [1:0]    mem_wdata;

   // clearing sweep owns the write port until done
   always_comb begin
      mem_we    = clr_ff | wr_en;
      mem_waddr = clr_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clr_ff ? 2'b00 : wr_data;
   end

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == AW'(MAX_SIZE - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   // a write landing on the address being read wins over the stale RAM word
   assign byp_hit_in = rd_en & wr_en & (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         byp_hit_ff  <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         byp_hit_ff  <= byp_hit_in;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;
   assign busy    = clr_ff;

endmodule

>>> hdl/btm_match.sv
// Window shift registers and the mask test for one pixel step.
// Depends on btm_pkg (pattern struct, mirror helper).
module btm_match #(
   parameter int MAX_SIZE  = btm_pkg::MAX_SIZE_DEF,
   parameter int MAX_PAT_W = btm_pkg::MAX_PAT_W_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           pixel,
   input  logic                           up1,
   input  logic                           up2,
   input  logic [$clog2(MAX_SIZE)-1:0]    row,
   input  logic [$clog2(MAX_SIZE)-1:0]    col,
   input  btm_pkg::btm_pat_type           pat,
   output logic                           hit,
   output logic [btm_pkg::OUT_W-1:0]      top_row,
   output logic [btm_pkg::OUT_W-1:0]      top_col
);
   import btm_pkg::*;

   localparam int CW = $clog2(MAX_SIZE);
   localparam int WW = (MAX_PAT_W < 32) ? MAX_PAT_W : 32;
   localparam int XW = (CW + 1 > OUT_W + 1) ? CW + 1 : OUT_W + 1;

   // win[0] = row r-2, win[1] = row r-1, win[2] = row r; bit 0 newest column
   logic [WW-1:0] win_ff [3];
   logic [WW-1:0] win_in [3];
   logic [31:0]   mir_top, mir_mid, mir_bot;
   logic [WW-1:0] need0, need1, need2;
   logic [XW-1:0] row_x, col_x, tr_x, tc_x;
   logic          fits, ok;

   always_comb begin
      win_in = win_ff;
      if (step) begin
         win_in[0] = (win_ff[0] << 1) | WW'(up2);
         win_in[1] = (win_ff[1] << 1) | WW'(up1);
         win_in[2] = (win_ff[2] << 1) | WW'(pixel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   assign mir_top = btm_mirror(pat.mask_top, pat.width);
   assign mir_mid = btm_mirror(pat.mask_mid, pat.width);
   assign mir_bot = btm_mirror(pat.mask_bot, pat.width);

   // mask rows sit on the bottom rows of the window
   always_comb begin
      need0 = '0;
      need1 = '0;
      need2 = '0;
      case (pat.height)
         2'd1: begin
            need2 = mir_top[WW-1:0];
         end
         2'd2: begin
            need1 = mir_top[WW-1:0];
            need2 = mir_mid[WW-1:0];
         end
         default: begin
            need0 = mir_top[WW-1:0];
            need1 = mir_mid[WW-1:0];
            need2 = mir_bot[WW-1:0];
         end
      endcase
   end

   always_comb begin
      row_x = XW'(row) + XW'(1);
      col_x = XW'(col) + XW'(1);
      fits  = (row_x >= XW'(pat.height)) && (col_x >= XW'(pat.width));
      ok    = ((win_in[0] & need0) == need0) && ((win_in[1] & need1) == need1)
              && ((win_in[2] & need2) == need2);
      tr_x  = row_x - XW'(pat.height);
      tc_x  = col_x - XW'(pat.width);
   end

   assign hit     = step & fits & ok;
   assign top_row = tr_x[OUT_W-1:0];
   assign top_col = tc_x[OUT_W-1:0];

endmodule

>>> hdl/btm_rsp_fifo.sv
// Result queue between the match stage and the rsp channel.
// Depends on btm_pkg (result struct, depth).
module btm_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  btm_pkg::btm_rsp_type      push_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output btm_pkg::btm_rsp_type      rsp_data,
   output logic [1:0]                count
);
   import btm_pkg::*;

   btm_rsp_type entry_ff [RSP_DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

>>> tb/sv/binary_template_match_2d_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_template_match_2d_top: a bit-true matcher model
// predicts each window hit, a monitor checks the result items. Needs btm_pkg and the RTL.
module binary_template_match_2d_top_tb;
   import btm_pkg::*;

   localparam int MAX_SIDE      = MAX_SIZE_DEF;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;     // pipeline latency plus margin
   localparam int RANDOM_ITEMS  = 390;
   localparam int HOLD_CYCLES   = 200;

   // Index values past the last register: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_PATTERN, RSP_SPARSE} rsp_mode_type;

   // DUT connections, all inputs known from time zero
   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic                  req_pixel   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [OUT_W-1:0]      rsp_top_row;
   logic [OUT_W-1:0]      rsp_top_col;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   // Matcher model: configuration as written, then raster state
   logic [7:0]  cfg_size     = RST_IMAGE_SIZE;
   logic [1:0]  cfg_height   = RST_PAT_HEIGHT;
   logic [5:0]  cfg_width    = RST_PAT_WIDTH;
   logic [31:0] pattern_mask [0:2];
   logic        line_prev    [0:MAX_SIDE-1];
   logic        line_older   [0:MAX_SIDE-1];
   logic [31:0] win_rows     [0:2];
   int          pos_row = 0;
   int          pos_col = 0;

   btm_rsp_type expected_hits[$];

   // Bookkeeping
   int           items_sent  = 0;
   int           cycle_count = 0;
   bit           failed      = 1'b0;
   rsp_mode_type rsp_mode    = RSP_ALWAYS;
   logic [15:0]  stall_pattern = 16'hFFFF;
   int           hold_len    = 0;

   binary_template_match_2d_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel   (req_pixel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_top_row (rsp_top_row),
      .rsp_top_col (rsp_top_col),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Line stores and window start cleared, as after the reset sweep
   initial begin
      pattern_mask[0] = RST_MASK_TOP;
      pattern_mask[1] = RST_MASK_MID;
      pattern_mask[2] = RST_MASK_BOT;
      for (int i = 0; i < MAX_SIDE; i++) begin
         line_prev[i]  = 1'b0;
         line_older[i] = 1'b0;
      end
      for (int i = 0; i < 3; i++) win_rows[i] = '0;
   end

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------

   // Relative mask column j is compared against window bit w-1-j
   function automatic logic [31:0] flip_mask(input logic [31:0] m, input int w);
      logic [31:0] r;
      r = '0;
      for (int j = 0; j < w; j++) begin
         if (m[j]) r[w-1-j] = 1'b1;
      end
      return r;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_IMAGE_SIZE: cfg_size        = data[7:0];
         REG_PAT_HEIGHT: cfg_height      = data[1:0];
         REG_PAT_WIDTH:  cfg_width       = data[5:0];
         REG_MASK_TOP:   pattern_mask[0] = data;
         REG_MASK_MID:   pattern_mask[1] = data;
         REG_MASK_BOT:   pattern_mask[2] = data;
         default: ;
      endcase
   endfunction

   // One pixel in; returns 1 with the top-left corner when the window ending here hits
   function automatic logic raster_match_step(input logic px, output btm_rsp_type pos);
      int          n, h, w;
      logic        up1, up2, hit;
      logic [31:0] need;
      n = (cfg_size == 0) ? 1 : ((cfg_size > MAX_SIDE) ? MAX_SIDE : int'(cfg_size));
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      w = (cfg_width == 0) ? 1 : ((cfg_width > 32) ? 32 : int'(cfg_width));
      hit = 1'b0;
      pos = '0;
      // counters kept over a size change: fold them back into the new image
      if (pos_col >= n) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row >= n) pos_row = 0;
      up1 = line_prev[pos_col];
      up2 = line_older[pos_col];
      line_older[pos_col] = up1;
      line_prev[pos_col]  = px;
      win_rows[0] = {win_rows[0][30:0], up2};
      win_rows[1] = {win_rows[1][30:0], up1};
      win_rows[2] = {win_rows[2][30:0], px};
      if (pos_row + 1 >= h && pos_col + 1 >= w) begin
         hit = 1'b1;
         for (int k = 0; k < h; k++) begin
            need = flip_mask(pattern_mask[k], w);
            if ((win_rows[3 - h + k] & need) != need) hit = 1'b0;
         end
         if (hit) begin
            pos.top_row = OUT_W'(pos_row + 1 - h);
            pos.top_col = OUT_W'(pos_col + 1 - w);
         end
      end
      pos_col++;
      if (pos_col >= n) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= n) pos_row = 0;
      end
      return hit;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers; every task starts and ends on a falling edge
   // ------------------------------------------------------------------

   // Offer one pixel item and hold it until taken; valid is left high so a
   // following item goes out back to back
   task automatic send_pixel(input logic px);
      btm_rsp_type hit_pos;
      logic        hit;
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      hit = raster_match_step(px, hit_pos);
      if (hit) expected_hits = {expected_hits, hit_pos};
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Sender stops and waits for every outstanding result, then lets the pipe settle
   task automatic pause_sender();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
   endtask

   // Full register load while idle; unused upper data bits carry junk
   task automatic load_pattern(input logic [7:0] size, input logic [1:0] height,
                               input logic [5:0] width, input logic [31:0] top,
                               input logic [31:0] mid, input logic [31:0] bot);
      logic [31:0] junk;
      pause_sender();
      junk = $urandom();
      csr_write(REG_IMAGE_SIZE, {junk[31:8], size});
      csr_write(REG_PAT_HEIGHT, {junk[31:2], height});
      csr_write(REG_PAT_WIDTH,  {junk[31:6], width});
      csr_write(REG_MASK_TOP, top);
      csr_write(REG_MASK_MID, mid);
      csr_write(REG_MASK_BOT, bot);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side: stall pattern, long hold-off and the checker
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int held;
      int beat;
      beat = 0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            // long hold-off, counted here so the sender keeps offering meanwhile
            rsp_ready <= 1'b0;
            for (held = 0; held < hold_len; held++) @(negedge clock);
            hold_len = 0;
         end
         case (rsp_mode)
            RSP_ALWAYS:  rsp_ready <= 1'b1;
            RSP_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
            RSP_PATTERN: rsp_ready <= stall_pattern[beat % 16];
            default:     rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         beat++;
      end
   end

   always @(posedge clock) begin
      btm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result item, expected none actual row %0d col %0d",
                     $time, rsp_top_row, rsp_top_col);
            failed = 1'b1;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_top_row !== want.top_row) begin
               $display("%0t: top_row mismatch, expected %0d actual %0d", $time,
                        want.top_row, rsp_top_row);
               failed = 1'b1;
            end
            if (rsp_top_col !== want.top_col) begin
               $display("%0t: top_col mismatch, expected %0d actual %0d", $time,
                        want.top_col, rsp_top_col);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL binary_template_match_2d_top");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: 96-wide image, 3x20 pattern; a few pixels test no window
   task automatic test_reset_defaults();
      repeat (4) send_pixel(1'b1);
   endtask

   // Size, height and width of zero all count as one; every pixel is a whole
   // image, so counters wrap on each item. Left-over counters from the
   // previous setting are folded back in.
   task automatic test_single_pixel_image();
      load_pattern(8'd0, 2'd0, 6'd0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
   endtask

   // No mask bits: every in-image window hits, even on a blank image
   task automatic test_empty_mask();
      load_pattern(8'd2, 2'd1, 6'd1, 32'h0, 32'h0, 32'h0);
      repeat (4) send_pixel(1'b0);
   endtask

   // Two rows in use: top row on image row 0, mid row on image row 1;
   // bottom mask is not looked at
   task automatic test_row_masks();
      load_pattern(8'd2, 2'd2, 6'd2, 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b0);
      send_pixel(1'b1);
   endtask

   // Writes to indexes past the register file leave the set-up alone
   task automatic test_spare_registers();
      pause_sender();
      csr_write(REG_SPARE_LO, $urandom());
      csr_write(REG_SPARE_HI, $urandom());
      csr_valid <= 1'b0;
      @(negedge clock);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b1);
   endtask

   // 3x3 window over a 3x3 image; mask bits at or above the width are ignored.
   // Only the window at the corner lies inside the image.
   task automatic test_full_window();
      load_pattern(8'd3, 2'd3, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (9) send_pixel(1'b1);
   endtask

   // Oversized settings saturate: 255 -> 128 wide image, width 63 -> 32
   task automatic test_wide_image();
      load_pattern(8'd255, 2'd1, 6'd63, 32'h8000_0001, $urandom(), $urandom());
      repeat (140) send_pixel($urandom_range(0, 9) != 0);
   endtask

   // Every pixel hits while the receiver holds off: the result queue fills and
   // the input has to stall, then everything drains
   task automatic test_backpressure();
      load_pattern(8'd4, 2'd1, 6'd1, 32'h0, 32'h0, 32'h0);
      rsp_mode = RSP_ALWAYS;
      hold_len = HOLD_CYCLES;
      repeat (40) send_pixel($urandom_range(0, 1));
      pause_sender();
   endtask

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom() & $urandom() & $urandom();
      endcase
   endfunction

   // Random set-ups, mostly small images with dense pixels and sparse masks so
   // windows hit often; the sender works in bursts, the receiver varies its stalls
   task automatic test_random_phases();
      int          first_items, n, limit_w, count, sent, burst, density;
      bit          gappy;
      logic [7:0]  size;
      logic [5:0]  width;
      first_items = items_sent;
      while (items_sent - first_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       size = 8'd0;
            1:       size = 8'd128;
            2:       size = 8'($urandom_range(129, 255));
            3:       size = 8'($urandom_range(9, 127));
            default: size = 8'($urandom_range(1, 8));
         endcase
         n = (size == 0) ? 1 : ((size > MAX_SIDE) ? MAX_SIDE : int'(size));
         limit_w = (n > 32) ? 32 : n;
         if ($urandom_range(0, 7) == 0) width = 6'($urandom_range(33, 63));
         else width = 6'($urandom_range(0, limit_w));
         load_pattern(size, 2'($urandom_range(0, 3)), width,
                      pick_mask(), pick_mask(), pick_mask());

         if (n <= 12) count = $urandom_range(n * n, 3 * n * n) + 4;
         else count = $urandom_range(n + 8, n + 72);
         // keep the total close to the planned item count
         if (count > RANDOM_ITEMS - (items_sent - first_items)) begin
            count = RANDOM_ITEMS - (items_sent - first_items);
         end
         case ($urandom_range(0, 4))
            0:       density = 100;
            1:       density = 90;
            2:       density = 70;
            3:       density = 50;
            default: density = 5;
         endcase
         rsp_mode      = rsp_mode_type'($urandom_range(0, 3));
         stall_pattern = 16'($urandom()) | 16'h0001;
         gappy         = ($urandom_range(0, 3) != 0);

         sent = 0;
         while (sent < count) begin
            burst = gappy ? $urandom_range(1, 24) : count;
            for (int i = 0; i < burst && sent < count; i++) begin
               send_pixel($urandom_range(0, 99) < density);
               sent++;
            end
            if (gappy) idle_gap($urandom_range(1, 8));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rsp_mode = RSP_ALWAYS;
      test_reset_defaults();
      test_single_pixel_image();
      test_empty_mask();
      test_row_masks();
      test_spare_registers();
      test_full_window();
      test_wide_image();
      test_backpressure();
      test_random_phases();

      // all stimulus taken: wait out the last results and a quiet tail
      pause_sender();
      if (!failed) begin
         $display("PASS binary_template_match_2d_top");
      end else begin
         $display("FAIL binary_template_match_2d_top");
      end
      $finish;
   end

endmodule
